// ===== hdl/wps_pkg.sv =====
`default_nettype none
package wps_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [5:0] MIN_TOTAL_LEN = 6'd44;
    localparam logic [3:0] RIFF_HDR_LEN  = 4'd12;
    localparam logic [3:0] CHUNK_HDR_LEN = 4'd8;
    localparam logic [3:0] MAGIC_LEN     = 4'd4;
    localparam logic [3:0] WAVE_POS      = 4'd8;

    localparam logic [31:0] MAGIC_RIFF = 32'h4646_4952;
    localparam logic [31:0] MAGIC_WAVE = 32'h4556_4157;
    localparam logic [31:0] MAGIC_DATA = 32'h6174_6164;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [1:0] ST_NO_DATA    = 2'd2;
    localparam logic [1:0] ST_NO_SAMPLES = 2'd3;

    typedef enum logic [2:0] {
        PH_RIFF = 3'd0,
        PH_CHDR = 3'd1,
        PH_SKIP = 3'd2,
        PH_DATA = 3'd3,
        PH_TAIL = 3'd4,
        PH_SINK = 3'd5
    } t_phase;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               sample_valid;
        logic               done_res;
        logic [1:0]         status;
    } t_out;

    function automatic logic [7:0] magic_byte(input logic [31:0] word, input logic [1:0] idx);
        magic_byte = word[{idx, 3'b000} +: 8];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/wav_pcm16_stream_extractor.sv =====
// A result word is queued when its byte is accepted and reaches o_out_data after older words.
// One byte per cycle while o_in_stall is low; counters and compares are combinational.
// A queue of QUEUE_DEPTH words lets the output side stall; o_in_stall rises only when it fills.
// Reset (synchronous, active low) clears the parser, the queue and raw_mode.
// A raw_mode write also restarts the buffer in progress.
`default_nettype none
module wav_pcm16_stream_extractor #(
    parameter int QUEUE_DEPTH = wps_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_wdata,
    input  wire logic          i_in_valid,
    input  wire wps_pkg::t_in  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output wps_pkg::t_out      o_out_data,
    input  wire logic          i_out_stall
);

    logic          accept;
    logic          push;
    logic          full;
    wps_pkg::t_out word;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    wps_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_item      (i_in_data),
        .o_push      (push),
        .o_word      (word)
    );

    wps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (word),
        .o_full  (full),
        .o_valid (o_out_valid),
        .o_word  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule
`default_nettype wire

// ===== hdl/wps_front.sv =====
`default_nettype none
module wps_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_wdata,
    input  wire logic          i_accept,
    input  wire wps_pkg::t_in  i_item,
    output logic               o_push,
    output wps_pkg::t_out      o_word
);

    logic            r_raw;
    wps_pkg::t_phase r_phase, n_phase;
    logic [3:0]      r_pos, n_pos;
    logic [5:0]      r_len, n_len;
    logic            r_hok, n_hok;
    logic            r_tag, n_tag;
    logic [31:0]     r_cl, n_cl;
    logic [32:0]     r_bl, n_bl;
    logic [7:0]      r_low, n_low;
    logic            r_have, n_have;
    logic            r_any, n_any;

    logic            got;
    logic [15:0]     smp;
    logic [1:0]      st;
    logic [7:0]      b;

    always_comb begin
        b       = i_item.byte_in;
        n_phase = r_phase;
        n_pos   = r_pos;
        n_hok   = r_hok;
        n_tag   = r_tag;
        n_cl    = r_cl;
        n_bl    = r_bl;
        n_low   = r_low;
        n_have  = r_have;
        n_any   = r_any;
        got     = 1'b0;
        smp     = 16'd0;
        st      = wps_pkg::ST_OK;
        n_len   = (r_len < wps_pkg::MIN_TOTAL_LEN) ? r_len + 6'd1 : r_len;

        if (r_raw || r_phase == wps_pkg::PH_DATA) begin
            if (!r_have) begin
                n_low  = b;
                n_have = 1'b1;
            end else begin
                smp    = {b, r_low};
                n_have = 1'b0;
                n_any  = 1'b1;
                got    = 1'b1;
            end
        end

        if (!r_raw) begin
            unique case (r_phase)
                wps_pkg::PH_RIFF: begin
                    if (r_pos < wps_pkg::MAGIC_LEN) begin
                        if (b != wps_pkg::magic_byte(wps_pkg::MAGIC_RIFF, r_pos[1:0]))
                            n_hok = 1'b0;
                    end else if (r_pos >= wps_pkg::WAVE_POS) begin
                        if (b != wps_pkg::magic_byte(wps_pkg::MAGIC_WAVE, r_pos[1:0]))
                            n_hok = 1'b0;
                    end
                    n_pos = r_pos + 4'd1;
                    if (n_pos >= wps_pkg::RIFF_HDR_LEN) begin
                        n_pos   = 4'd0;
                        n_tag   = 1'b1;
                        n_phase = n_hok ? wps_pkg::PH_CHDR : wps_pkg::PH_SINK;
                    end
                end
                wps_pkg::PH_CHDR: begin
                    if (r_pos < wps_pkg::MAGIC_LEN) begin
                        if (b != wps_pkg::magic_byte(wps_pkg::MAGIC_DATA, r_pos[1:0]))
                            n_tag = 1'b0;
                    end else begin
                        n_cl = {b, r_cl[31:8]};
                    end
                    n_pos = r_pos + 4'd1;
                    if (n_pos >= wps_pkg::CHUNK_HDR_LEN) begin
                        n_pos = 4'd0;
                        if (r_tag) begin
                            n_bl    = {1'b0, n_cl};
                            n_phase = (n_cl == 32'd0) ? wps_pkg::PH_TAIL : wps_pkg::PH_DATA;
                        end else begin
                            n_bl    = {1'b0, n_cl} + {32'd0, n_cl[0]};
                            n_tag   = 1'b1;
                            n_phase = (n_cl == 32'd0) ? wps_pkg::PH_CHDR : wps_pkg::PH_SKIP;
                        end
                    end
                end
                wps_pkg::PH_SKIP: begin
                    n_bl = r_bl - 33'd1;
                    if (r_bl == 33'd1) n_phase = wps_pkg::PH_CHDR;
                end
                wps_pkg::PH_DATA: begin
                    n_bl = r_bl - 33'd1;
                    if (r_bl == 33'd1) n_phase = wps_pkg::PH_TAIL;
                end
                default: begin
                end
            endcase
        end

        if (i_item.last_byte) begin
            if (r_raw) begin
                st = n_any ? wps_pkg::ST_OK : wps_pkg::ST_NO_SAMPLES;
            end else if (!n_hok || n_len < wps_pkg::MIN_TOTAL_LEN
                         || n_phase == wps_pkg::PH_RIFF || n_phase == wps_pkg::PH_SINK) begin
                st = wps_pkg::ST_BAD_HEADER;
            end else if (n_phase == wps_pkg::PH_DATA || n_phase == wps_pkg::PH_TAIL) begin
                st = n_any ? wps_pkg::ST_OK : wps_pkg::ST_NO_SAMPLES;
            end else begin
                st = wps_pkg::ST_NO_DATA;
            end
        end

        o_push              = i_accept && (got || i_item.last_byte);
        o_word.sample       = smp;
        o_word.sample_valid = got;
        o_word.done_res     = i_item.last_byte;
        o_word.status       = st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_accept && i_item.last_byte)) begin
            r_phase <= wps_pkg::PH_RIFF;
            r_pos   <= 4'd0;
            r_len   <= 6'd0;
            r_hok   <= 1'b1;
            r_tag   <= 1'b1;
            r_cl    <= 32'd0;
            r_bl    <= 33'd0;
            r_low   <= 8'd0;
            r_have  <= 1'b0;
            r_any   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_hok   <= n_hok;
            r_tag   <= n_tag;
            r_cl    <= n_cl;
            r_bl    <= n_bl;
            r_low   <= n_low;
            r_have  <= n_have;
            r_any   <= n_any;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw <= 1'b0;
        end else if (i_cfg_we) begin
            r_raw <= i_cfg_wdata;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/wps_queue.sv =====
`default_nettype none
module wps_queue #(
    parameter int DEPTH = wps_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire wps_pkg::t_out i_word,
    output logic               o_full,
    output logic               o_valid,
    output wps_pkg::t_out      o_word,
    input  wire logic          i_stall
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    wps_pkg::t_out r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            if (pop)    r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            if (i_push && !pop)      r_count <= r_count + CW'(1);
            else if (!i_push && pop) r_count <= r_count - CW'(1);
        end
    end

endmodule
`default_nettype wire
